// File: rtl/uer_pkg.sv
`timescale 1ns / 1ps

package uer_pkg;

  // Fixed field widths
  localparam int TRIG_BITS  = 8;
  localparam int TMO_BITS   = 24;
  localparam int TPC_BITS   = 8;
  localparam int DIST_BITS  = 24;
  localparam int CFG_W      = 24;
  localparam int CFG_IDX_W  = 2;

  // Default counter width and register reset values
  localparam int COUNT_BITS_DEF = 24;
  localparam logic [TRIG_BITS-1:0] TRIG_RESET = TRIG_BITS'(10);
  localparam logic [TMO_BITS-1:0]  TMO_RESET  = TMO_BITS'(1000000);
  localparam logic [TPC_BITS-1:0]  TPC_RESET  = TPC_BITS'(58);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TRIGGER = 2'd0,
    CFG_TIMEOUT = 2'd1,
    CFG_TPC     = 2'd2
  } cfg_idx_t;

  // Controller to datapath
  typedef struct packed {
    logic step;       // input transfer: update measurement state
    logic load_now;   // load output from this item's result
    logic div_start;  // start pulse width division
    logic load_div;   // load output from the divider result
  } uer_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_div;   // current item ends a pulse
    logic div_busy;   // divider still iterating
  } uer_stat_t;

endpackage

// File: rtl/ultrasonic_echo_ranger.sv
`timescale 1ns / 1ps

// Ultrasonic time-of-flight ranger. Each input transfer is one microsecond tick
// carrying a start request and the sampled echo level; each tick yields exactly one
// result transfer with trigger drive, busy, done, no-echo and the held distance.
// A start raises the trigger for trigger_ticks ticks, then the echo pulse width is
// counted and divided by ticks_per_cm on the falling edge; timeout_ticks after the
// start without a falling edge reports no echo. An ordinary tick's result is registered
// directly when the output register is free. The tick that ends an echo pulse also runs
// the bit-serial divider (one quotient bit per cycle), during which input is stalled.
// The user must write registers only while idle; the block itself does not enforce it.
module ultrasonic_echo_ranger #(
  parameter int COUNT_BITS = uer_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [uer_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [uer_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_start_request,
  input  logic                          in_echo_level,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_trigger_out,
  output logic                          out_busy_res,
  output logic                          out_measurement_done,
  output logic                          out_no_echo,
  output logic [uer_pkg::DIST_BITS-1:0] out_distance_cm
);
  import uer_pkg::*;

  uer_cmd_t  cmd;
  uer_stat_t stat;

  uer_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  uer_datapath #(
    .COUNT_BITS(COUNT_BITS)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_start_request     (in_start_request),
    .in_echo_level        (in_echo_level),
    .cmd                  (cmd),
    .stat                 (stat),
    .out_trigger_out      (out_trigger_out),
    .out_busy_res         (out_busy_res),
    .out_measurement_done (out_measurement_done),
    .out_no_echo          (out_no_echo),
    .out_distance_cm      (out_distance_cm)
  );

  // a tick that ends a pulse blocks input while dividing
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> in_stall)
    else $error("input not stalled during division");

  // a finished measurement never reports busy
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_measurement_done |-> !out_busy_res)
    else $error("done and busy together");

  // no echo only comes with done
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_no_echo |-> out_measurement_done)
    else $error("no echo without done");

  // divider result is never loaded twice from one start
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_div |=> !cmd.load_div)
    else $error("divider result loaded twice");

endmodule

// File: rtl/uer_div.sv
`timescale 1ns / 1ps

module uer_div #(
  parameter int COUNT_BITS = uer_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [COUNT_BITS-1:0]         dividend,
  input  logic [uer_pkg::TPC_BITS-1:0]  divisor,
  output logic                          busy,
  output logic [uer_pkg::DIST_BITS-1:0] quotient
);
  import uer_pkg::*;

  localparam int CNT_W = $clog2(COUNT_BITS + 1);
  localparam int EXT_W = (COUNT_BITS > DIST_BITS) ? COUNT_BITS : DIST_BITS;

  logic                busy_r, busy_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [COUNT_BITS-1:0] quo_r, quo_nxt;
  logic [TPC_BITS-1:0] rem_r, rem_nxt;
  logic [TPC_BITS-1:0] dvs_r, dvs_nxt;
  logic [TPC_BITS:0]   rem_sh;
  logic [EXT_W-1:0]    quo_ext;

  // Restoring division, one quotient bit per cycle
  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    rem_sh   = {rem_r, quo_r[COUNT_BITS-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(COUNT_BITS);
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = (divisor == '0) ? TPC_BITS'(1) : divisor;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, dvs_r}) begin
        rem_nxt = TPC_BITS'(rem_sh - {1'b0, dvs_r});
        quo_nxt = {quo_r[COUNT_BITS-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[TPC_BITS-1:0];
        quo_nxt = {quo_r[COUNT_BITS-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  // Saturate to the distance width
  assign quo_ext  = EXT_W'(quo_r);
  assign busy     = busy_r;
  assign quotient = (|(quo_ext >> DIST_BITS)) ? '1 : quo_ext[DIST_BITS-1:0];

endmodule

// File: rtl/uer_datapath.sv
`timescale 1ns / 1ps

module uer_datapath #(
  parameter int COUNT_BITS = uer_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [uer_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [uer_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                          in_start_request,
  input  logic                          in_echo_level,
  input  uer_pkg::uer_cmd_t             cmd,
  output uer_pkg::uer_stat_t            stat,
  output logic                          out_trigger_out,
  output logic                          out_busy_res,
  output logic                          out_measurement_done,
  output logic                          out_no_echo,
  output logic [uer_pkg::DIST_BITS-1:0] out_distance_cm
);
  import uer_pkg::*;

  localparam int EXT_W = (COUNT_BITS > TMO_BITS) ? COUNT_BITS : TMO_BITS;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_WAIT = 2'd1,
    PH_MEAS = 2'd2
  } phase_t;

  // Configuration
  logic [TRIG_BITS-1:0] trig_ticks_r;
  logic [TMO_BITS-1:0]  tmo_ticks_r;
  logic [TPC_BITS-1:0]  tpc_r;

  // Measurement state
  phase_t                phase_r, phase_nxt;
  logic [COUNT_BITS-1:0] elapsed_r, elapsed_nxt;
  logic [COUNT_BITS-1:0] pw_r, pw_nxt;
  logic                  echo_prev_r;
  logic [DIST_BITS-1:0]  dist_hold_r;
  logic                  pend_trig_r;

  // Output payload
  logic trig_out_r, busy_out_r, done_out_r, miss_out_r;

  logic trig_c, busy_c, done_c, miss_c, fin_c;
  logic [EXT_W-1:0] e_ext;
  logic div_busy;
  logic [DIST_BITS-1:0] div_q;

  assign e_ext = EXT_W'(elapsed_r);

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trig_ticks_r <= TRIG_RESET;
      tmo_ticks_r  <= TMO_RESET;
      tpc_r        <= TPC_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TRIGGER: trig_ticks_r <= cfg_wdata[TRIG_BITS-1:0];
        CFG_TIMEOUT: tmo_ticks_r  <= cfg_wdata[TMO_BITS-1:0];
        CFG_TPC:     tpc_r        <= cfg_wdata[TPC_BITS-1:0];
        default: ;
      endcase
    end
  end

  // One tick of the measurement
  always_comb begin
    phase_nxt   = phase_r;
    elapsed_nxt = elapsed_r;
    pw_nxt      = pw_r;
    trig_c      = 1'b0;
    busy_c      = 1'b0;
    done_c      = 1'b0;
    miss_c      = 1'b0;
    fin_c       = 1'b0;
    if (in_start_request) begin
      phase_nxt   = PH_WAIT;
      elapsed_nxt = COUNT_BITS'(1);
      pw_nxt      = '0;
      trig_c      = (trig_ticks_r != '0);
      busy_c      = 1'b1;
    end else begin
      unique case (phase_r) inside
        PH_WAIT, PH_MEAS: begin
          trig_c = (e_ext < EXT_W'(trig_ticks_r));
          if (phase_r == PH_WAIT) begin
            // rising edge opens the pulse
            if (in_echo_level && !echo_prev_r) begin
              phase_nxt = PH_MEAS;
              pw_nxt    = COUNT_BITS'(1);
            end
          end else if (in_echo_level) begin
            if (pw_r != '1) begin
              pw_nxt = pw_r + COUNT_BITS'(1);
            end
          end else begin
            fin_c  = 1'b1;
            done_c = 1'b1;
          end
          // timeout, or elapsed counter pinned at max
          if (!done_c && ((e_ext >= EXT_W'(tmo_ticks_r)) || (elapsed_r == '1))) begin
            done_c = 1'b1;
            miss_c = 1'b1;
          end
          if (done_c) begin
            phase_nxt = PH_IDLE;
          end else begin
            busy_c = 1'b1;
            if (elapsed_r != '1) begin
              elapsed_nxt = elapsed_r + COUNT_BITS'(1);
            end
          end
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end
  end

  assign stat.need_div = fin_c;
  assign stat.div_busy = div_busy;

  // State update on transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      elapsed_r   <= '0;
      pw_r        <= '0;
      echo_prev_r <= 1'b0;
      dist_hold_r <= '0;
    end else begin
      if (cmd.step) begin
        phase_r     <= phase_nxt;
        elapsed_r   <= elapsed_nxt;
        pw_r        <= pw_nxt;
        echo_prev_r <= in_echo_level;
      end
      if (cmd.load_div) begin
        dist_hold_r <= div_q;
      end
    end
  end

  // Output payload registers
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      pend_trig_r <= trig_c;
    end
    if (cmd.load_now) begin
      trig_out_r <= trig_c;
      busy_out_r <= busy_c;
      done_out_r <= done_c;
      miss_out_r <= miss_c;
    end else if (cmd.load_div) begin
      trig_out_r <= pend_trig_r;
      busy_out_r <= 1'b0;
      done_out_r <= 1'b1;
      miss_out_r <= 1'b0;
    end
  end

  uer_div #(
    .COUNT_BITS(COUNT_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (pw_r),
    .divisor  (tpc_r),
    .busy     (div_busy),
    .quotient (div_q)
  );

  assign out_trigger_out      = trig_out_r;
  assign out_busy_res         = busy_out_r;
  assign out_measurement_done = done_out_r;
  assign out_no_echo          = miss_out_r;
  assign out_distance_cm      = dist_hold_r;

endmodule

// File: rtl/uer_ctrl.sv
`timescale 1ns / 1ps

module uer_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  uer_pkg::uer_stat_t stat,
  output uer_pkg::uer_cmd_t  cmd
);
  import uer_pkg::*;

  typedef enum logic {
    ST_TICK,
    ST_DIV
  } state_t;

  state_t state_r;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;
  logic   accept;

  // output slot free this cycle
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r == ST_DIV) || !out_free;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    cmd.step      = accept;
    cmd.load_now  = accept && !stat.need_div;
    cmd.div_start = accept && stat.need_div;
    cmd.load_div  = (state_r == ST_DIV) && !stat.div_busy && out_free;
  end

  // result slot: empties on transfer, fills on either load
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.load_now || cmd.load_div) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_TICK;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      unique case (state_r)
        ST_TICK: begin
          if (cmd.div_start) begin
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (cmd.load_div) begin
            state_r <= ST_TICK;
          end
        end
        default: state_r <= ST_TICK;
      endcase
    end
  end

  assign out_valid = out_valid_r;

endmodule

// File: tb/ultrasonic_echo_ranger_tb.sv
`timescale 1ns / 1ps

module ultrasonic_echo_ranger_tb;
  import uer_pkg::*;

  localparam int CNT_BITS = COUNT_BITS_DEF;
  localparam logic [CNT_BITS-1:0] CNT_MAX = {CNT_BITS{1'b1}};
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES = 80;

  // One result transfer per tick
  typedef struct packed {
    logic                 trig;
    logic                 busy;
    logic                 done;
    logic                 miss;
    logic [DIST_BITS-1:0] dist_cm;
  } tick_result_t;

  // Directed table row: either a register write or one tick
  typedef struct packed {
    bit               cfg;
    cfg_idx_t         idx;
    logic [CFG_W-1:0] value;
    bit               start;
    bit               echo;
    bit               typed;
    tick_result_t     want;
  } drow_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ARMED,
    ST_PULSE
  } ranger_state_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_TRIGGER;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_start_request = 1'b0;
  logic                 in_echo_level = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_trigger_out;
  logic                 out_busy_res;
  logic                 out_measurement_done;
  logic                 out_no_echo;
  logic [DIST_BITS-1:0] out_distance_cm;

  ultrasonic_echo_ranger dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_start_request    (in_start_request),
    .in_echo_level       (in_echo_level),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_trigger_out     (out_trigger_out),
    .out_busy_res        (out_busy_res),
    .out_measurement_done(out_measurement_done),
    .out_no_echo         (out_no_echo),
    .out_distance_cm     (out_distance_cm)
  );

  always #4 clk = ~clk;

  // Ranger state as the testbench sees it
  logic [TRIG_BITS-1:0] cfg_trig = TRIG_RESET;
  logic [TMO_BITS-1:0]  cfg_tmo  = TMO_RESET;
  logic [TPC_BITS-1:0]  cfg_tpc  = TPC_RESET;
  ranger_state_t        rng_state = ST_IDLE;
  logic [CNT_BITS-1:0]  elapsed_cnt = '0;
  logic [CNT_BITS-1:0]  pulse_cnt = '0;
  logic                 echo_last = 1'b0;
  logic [DIST_BITS-1:0] dist_held = '0;

  tick_result_t expected_q[$];
  tick_result_t got_res;
  tick_result_t want_res;
  int  items_sent = 0;
  int  results_seen = 0;
  int  mismatch_count = 0;
  int  idle_pct = 0;
  bit  hold_done = 1'b0;

  // Advance the ranger by one tick and return its result
  function automatic tick_result_t predict_tick(input bit start, input bit echo);
    tick_result_t        r;
    logic [CNT_BITS-1:0] e;
    logic [CNT_BITS-1:0] q;
    logic [TPC_BITS-1:0] div;
    r = '0;
    if (start) begin
      // start (or restart): drop any capture, first trigger tick
      rng_state   = ST_ARMED;
      pulse_cnt   = '0;
      r.trig      = (cfg_trig != 0);
      r.busy      = 1'b1;
      elapsed_cnt = CNT_BITS'(1);
    end else if (rng_state == ST_ARMED || rng_state == ST_PULSE) begin
      e = elapsed_cnt;
      r.trig = (e < cfg_trig);
      if (rng_state == ST_ARMED) begin
        if (echo && !echo_last) begin
          rng_state = ST_PULSE;
          pulse_cnt = CNT_BITS'(1);
        end
      end else if (echo) begin
        if (pulse_cnt != CNT_MAX) pulse_cnt = pulse_cnt + 1'b1;
      end else begin
        // falling edge: divide, zero divisor counts as one
        div = (cfg_tpc == 0) ? TPC_BITS'(1) : cfg_tpc;
        q = pulse_cnt / div;
        dist_held = (64'(q) > 64'hFF_FFFF) ? {DIST_BITS{1'b1}} : DIST_BITS'(q);
        r.done = 1'b1;
      end
      // falling edge wins over timeout in the same tick
      if (!r.done && (e >= cfg_tmo || e == CNT_MAX)) begin
        r.done = 1'b1;
        r.miss = 1'b1;
      end
      if (r.done) begin
        rng_state = ST_IDLE;
      end else begin
        r.busy = 1'b1;
        if (elapsed_cnt != CNT_MAX) elapsed_cnt = elapsed_cnt + 1'b1;
      end
    end else begin
      rng_state = ST_IDLE;
    end
    echo_last = echo;
    r.dist_cm = dist_held;
    return r;
  endfunction

  function automatic tick_result_t tick_out(input bit t, input bit b, input bit d,
                                            input bit m, input logic [DIST_BITS-1:0] dcm);
    tick_result_t r;
    r.trig = t;
    r.busy = b;
    r.done = d;
    r.miss = m;
    r.dist_cm = dcm;
    return r;
  endfunction

  function automatic drow_t cfg_row(input cfg_idx_t idx, input logic [CFG_W-1:0] v);
    drow_t r;
    r = '0;
    r.cfg = 1'b1;
    r.idx = idx;
    r.value = v;
    return r;
  endfunction

  function automatic drow_t item_row(input bit s, input bit e);
    drow_t r;
    r = '0;
    r.start = s;
    r.echo = e;
    return r;
  endfunction

  function automatic drow_t check_row(input bit s, input bit e, input tick_result_t want);
    drow_t r;
    r = item_row(s, e);
    r.typed = 1'b1;
    r.want = want;
    return r;
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    if (mismatch_count < 50)
      $display("%0t: %s: got %0h, want %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // One tick transfer; random gap first when idling is on
  task automatic send_tick(input bit start, input bit echo, input bit typed = 1'b0,
                           input tick_result_t typed_res = '0);
    tick_result_t want;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_start_request <= start;
    in_echo_level    <= echo;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    want = predict_tick(start, echo);
    expected_q.push_back(typed ? typed_res : want);
    items_sent++;
  endtask

  // Stop offering and wait for every outstanding result
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    case (idx)
      CFG_TRIGGER: cfg_trig = v[TRIG_BITS-1:0];
      CFG_TIMEOUT: cfg_tmo  = v[TMO_BITS-1:0];
      CFG_TPC:     cfg_tpc  = v[TPC_BITS-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      got_res = tick_out(out_trigger_out, out_busy_res, out_measurement_done,
                         out_no_echo, out_distance_cm);
      if (expected_q.size() == 0) begin
        report("result with nothing expected", got_res, 0);
      end else begin
        want_res = expected_q.pop_front();
        if (got_res.trig !== want_res.trig) report("trigger_out", got_res.trig, want_res.trig);
        if (got_res.busy !== want_res.busy) report("busy_res", got_res.busy, want_res.busy);
        if (got_res.done !== want_res.done)
          report("measurement_done", got_res.done, want_res.done);
        if (got_res.miss !== want_res.miss) report("no_echo", got_res.miss, want_res.miss);
        if (got_res.dist_cm !== want_res.dist_cm)
          report("distance_cm", got_res.dist_cm, want_res.dist_cm);
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold while ticks keep coming
  initial begin
    forever begin
      @(posedge clk);
      if (!hold_done && results_seen >= 300 && in_valid) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog on cycles with no transfer anywhere
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || !rst_n)
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("Mismatches found");
    $finish;
  end

  // Stimulus
  initial begin
    drow_t dir_rows [32];
    int    ph;
    int    kind;
    int    w;
    int    n;
    int    phase_start;

    dir_rows = '{
      check_row(1'b0, 1'b1, tick_out(0, 0, 0, 0, 0)),
      cfg_row(CFG_TRIGGER, 24'd2),
      cfg_row(CFG_TIMEOUT, 24'd6),
      cfg_row(CFG_TPC, 24'd0),
      check_row(1'b1, 1'b1, tick_out(1, 1, 0, 0, 0)),
      item_row(1'b0, 1'b1),
      item_row(1'b0, 1'b0),
      item_row(1'b0, 1'b1),
      item_row(1'b0, 1'b1),
      item_row(1'b0, 1'b1),
      // falling edge lands in the timeout tick: distance wins
      check_row(1'b0, 1'b0, tick_out(0, 0, 1, 0, 3)),
      item_row(1'b1, 1'b0),
      item_row(1'b0, 1'b1),
      // restart mid-pulse: busy, no done
      check_row(1'b1, 1'b1, tick_out(1, 1, 0, 0, 3)),
      item_row(1'b0, 1'b0),
      item_row(1'b0, 1'b0),
      item_row(1'b0, 1'b0),
      item_row(1'b0, 1'b0),
      item_row(1'b0, 1'b0),
      // no echo keeps the held distance
      check_row(1'b0, 1'b0, tick_out(0, 0, 1, 1, 3)),
      cfg_row(CFG_TRIGGER, 24'd0),
      cfg_row(CFG_TIMEOUT, 24'd0),
      cfg_row(CFG_TPC, 24'd255),
      check_row(1'b1, 1'b0, tick_out(0, 1, 0, 0, 3)),
      check_row(1'b0, 1'b0, tick_out(0, 0, 1, 1, 3)),
      cfg_row(CFG_TRIGGER, 24'd255),
      cfg_row(CFG_TIMEOUT, 24'hFF_FFFF),
      cfg_row(CFG_TPC, 24'd1),
      check_row(1'b1, 1'b0, tick_out(1, 1, 0, 0, 3)),
      item_row(1'b0, 1'b1),
      item_row(1'b0, 1'b1),
      check_row(1'b0, 1'b0, tick_out(1, 0, 1, 0, 2))
    };

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table
    idle_pct = 20;
    for (int i = 0; i < 32; i++) begin
      if (dir_rows[i].cfg) begin
        drain();
        write_reg(dir_rows[i].idx, dir_rows[i].value);
      end else begin
        send_tick(dir_rows[i].start, dir_rows[i].echo, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    // Random phases, each with its own register settings
    for (ph = 0; ph < 8; ph++) begin
      drain();
      case (ph)
        0: begin
          write_reg(CFG_TRIGGER, 24'd255);
          write_reg(CFG_TIMEOUT, 24'hFF_FFFF);
          write_reg(CFG_TPC, 24'd255);
        end
        1: begin
          write_reg(CFG_TRIGGER, 24'd1);
          write_reg(CFG_TIMEOUT, 24'd1);
          write_reg(CFG_TPC, 24'd1);
        end
        default: begin
          write_reg(CFG_TRIGGER, CFG_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                                    : $urandom_range(0, 20)));
          write_reg(CFG_TIMEOUT, CFG_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 3)
                                                                    : $urandom_range(20, 400)));
          write_reg(CFG_TPC, CFG_W'(($urandom_range(0, 1) == 0) ? $urandom_range(0, 255)
                                                                : $urandom_range(1, 10)));
        end
      endcase
      // no idling in phase 3 and in the closing phase
      idle_pct = (ph == 3 || ph == 7) ? 0 : $urandom_range(10, 35);
      phase_start = items_sent;
      while (items_sent - phase_start < 50) begin
        kind = $urandom_range(0, 9);
        if (kind <= 5) begin
          // well-formed: start, quiet gap, echo pulse, falling edge
          send_tick(1'b1, $urandom_range(0, 3) == 0);
          repeat ($urandom_range(0, 12)) send_tick(1'b0, 1'b0);
          w = ($urandom_range(0, 29) == 0) ? $urandom_range(150, 400) : $urandom_range(1, 120);
          repeat (w) send_tick(1'b0, 1'b1);
          send_tick(1'b0, 1'b0);
          repeat ($urandom_range(0, 3)) send_tick(1'b0, $urandom_range(0, 1));
        end else if (kind == 6) begin
          // no echo: run into the timeout where it is short
          send_tick(1'b1, 1'b0);
          n = (cfg_tmo > 118) ? 120 : int'(cfg_tmo) + 2;
          repeat (n) send_tick(1'b0, 1'b0);
        end else if (kind == 7) begin
          // broken: the next start aborts this capture
          send_tick(1'b1, 1'b0);
          repeat ($urandom_range(0, 8)) send_tick(1'b0, $urandom_range(0, 1));
        end else begin
          // noise
          repeat ($urandom_range(4, 16))
            send_tick($urandom_range(0, 7) == 0, $urandom_range(0, 1));
        end
      end
    end

    drain();
    repeat (CNT_BITS + 8) @(posedge clk);
    if (mismatch_count == 0 && expected_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
